FILE: src/ide_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ide_pkg;

    localparam int LANES  = 8;
    localparam int WORD_W = 64;
    localparam int POS_W  = 13;
    localparam int ROW_W  = LANES * WORD_W;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   addr;
        logic [WORD_W-1:0]  value;
        logic               last;
    } rec_t;

    typedef struct packed {
        logic               cmd;
        logic               empty;
        logic               pass_end;
        logic [2:0]         lane;
        logic [POS_W-1:0]   pos;
        logic [WORD_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic               en;
        logic [LANES-1:0]   lanes;
        logic [ROW_W-1:0]   data;
    } wr_t;

endpackage
`default_nettype wire

FILE: src/ide_base_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module ide_base_mem
    import ide_pkg::*;
#(
    parameter int ROWS = 512,
    parameter int RAW  = 9
)
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [RAW-1:0]   rd_row,
    input  wire wr_t              wr,
    input  wire logic [RAW-1:0]   wr_row,
    output logic      [ROW_W-1:0] base_row
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;
    logic [ROW_W-1:0] fwd_data_reg;
    logic [LANES-1:0] fwd_mask_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (wr.lanes[k])
                begin
                    mem[wr_row][k*WORD_W +: WORD_W] <= wr.data[k*WORD_W +: WORD_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_row];
            fwd_data_reg <= wr.data;
            fwd_mask_reg <= (wr.en && (wr_row == rd_row)) ? wr.lanes : '0;
        end
    end

    // forward a write that lands on the row being read
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            base_row[k*WORD_W +: WORD_W] = fwd_mask_reg[k] ?
                fwd_data_reg[k*WORD_W +: WORD_W] : rd_data_reg[k*WORD_W +: WORD_W];
        end
    end

endmodule
`default_nettype wire

FILE: src/ide_issue.sv
`timescale 1ns / 1ps
`default_nettype none
module ide_issue
    import ide_pkg::*;
#(
    parameter int ROWS = 512,
    parameter int RAW  = 9
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              command,
    input  wire logic [11:0]       word_index,
    input  wire logic [WORD_W-1:0] word_value,
    output logic                   in_ready,
    input  wire logic              fire,
    input  wire logic              restart,
    input  wire logic [POS_W-1:0]  start_value,
    input  wire logic [POS_W-1:0]  end_value,
    output logic                   s1_valid,
    output item_t                  s1_item,
    output logic      [RAW-1:0]    s1_row,
    output logic                   rd_en,
    output logic      [RAW-1:0]    rd_row
);

    logic             s1_valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [RAW-1:0]   row_reg;
    logic [RAW-1:0]   row_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W:0]   pos_inc;
    logic             accept;

    assign in_ready = !s1_valid_reg || fire;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = item_reg;
    assign s1_row   = row_reg;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign rd_row   = RAW'((32'(pos_reg) >> 3) % ROWS);
    assign rd_en    = accept && (command == CMD_COMPARE);

    always_comb
    begin
        item_next          = '0;
        item_next.cmd      = command;
        item_next.value    = word_value;
        item_next.pos      = pos_reg;
        pos_next           = pos_reg;
        row_next           = rd_row;
        if (command == CMD_LOAD)
        begin
            item_next.lane = word_index[2:0];
            row_next       = RAW'((32'(word_index) >> 3) % ROWS);
        end
        else if (pos_reg >= end_value)
        begin
            item_next.empty = 1'b1;
            pos_next        = start_value;
        end
        else
        begin
            item_next.lane = pos_reg[2:0];
            pos_next       = pos_inc[POS_W-1:0];
            if ((pos_reg[2:0] == 3'd7) && (pos_inc >= {1'b0, end_value}))
            begin
                item_next.pass_end = 1'b1;
                pos_next           = start_value;
            end
        end
        if (restart)
        begin
            pos_next = start_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (accept || restart)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            row_reg  <= row_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/ide_core.sv
`timescale 1ns / 1ps
`default_nettype none
module ide_core
    import ide_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic              restart,
    input  wire item_t             item,
    input  wire logic [ROW_W-1:0]  base_row,
    input  wire logic [POS_W-1:0]  window,
    output wr_t                    wr,
    output rec_t                   recs [3],
    output logic      [1:0]        rec_cnt
);

    logic [WORD_W-1:0] gb_reg [LANES];
    logic [WORD_W-1:0] gb_next [LANES];
    logic [POS_W-1:0]  dc_reg, dc_next;
    logic [POS_W-1:0]  ha_reg, ha_next;
    logic [POS_W-1:0]  rs_reg, rs_next;
    logic [POS_W-1:0]  tc_reg, tc_next;
    logic              open_reg, open_next;
    logic [WORD_W-1:0] base_word;
    logic              changed;
    logic [POS_W-1:0]  gbase;
    logic [POS_W-1:0]  nxt;
    logic [POS_W-1:0]  endv;
    logic              fresh;
    logic              close;
    logic              rearm;
    logic [1:0]        n;

    assign base_word = base_row[item.lane*WORD_W +: WORD_W];
    assign changed   = item.value != base_word;
    assign gbase     = item.pos - POS_W'(7);
    assign nxt       = item.pos + POS_W'(1);

    always_comb
    begin
        gb_next   = gb_reg;
        dc_next   = dc_reg;
        ha_next   = ha_reg;
        rs_next   = rs_reg;
        tc_next   = tc_reg;
        open_next = open_reg;
        wr        = '0;
        n         = '0;
        fresh     = 1'b0;
        close     = 1'b0;
        endv      = '0;
        rearm     = restart;
        for (int k = 0; k < 3; k++)
        begin
            recs[k] = '0;
        end
        if (fire)
        begin
            if (item.cmd == CMD_LOAD)
            begin
                wr.en    = 1'b1;
                wr.lanes = LANES'(1) << item.lane;
                wr.data  = {LANES{item.value}};
            end
            else if (item.empty)
            begin
                recs[n] = '{KIND_DONE, '0, '0, 1'b0};
                n       = n + 2'd1;
                rearm   = 1'b1;
            end
            else
            begin
                gb_next[item.lane] = item.value;
                if (!open_next && changed)
                begin
                    open_next = 1'b1;
                    rs_next   = item.pos;
                    ha_next   = dc_next;
                    dc_next   = dc_next + POS_W'(1);
                end
                if (open_next)
                begin
                    recs[n] = '{KIND_DATA, dc_next, item.value, 1'b0};
                    n       = n + 2'd1;
                    dc_next = dc_next + POS_W'(1);
                    tc_next = changed ? '0 : tc_next + POS_W'(1);
                end
                if (item.lane == 3'd7)
                begin
                    fresh = open_next && (rs_next >= gbase);
                    close = open_next && !fresh && (tc_next > window);
                    if (open_next && !close)
                    begin
                        wr.en    = 1'b1;
                        wr.lanes = '1;
                        for (int k = 0; k < LANES; k++)
                        begin
                            wr.data[k*WORD_W +: WORD_W] = gb_next[k];
                        end
                    end
                    if (open_next && (close || item.pass_end))
                    begin
                        endv = nxt;
                        if (!fresh)
                        begin
                            // trim the trailing unchanged words
                            dc_next = dc_next - tc_next;
                            endv    = nxt - tc_next;
                        end
                        recs[n]   = '{KIND_HEADER, ha_next,
                                      {19'd0, endv, 19'd0, rs_next}, 1'b0};
                        n         = n + 2'd1;
                        open_next = 1'b0;
                        tc_next   = '0;
                    end
                    if (item.pass_end)
                    begin
                        recs[n] = '{KIND_DONE, dc_next, '0, 1'b0};
                        n       = n + 2'd1;
                        rearm   = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            recs[k].last = (2'(k) == n - 2'd1);
        end
        if (rearm)
        begin
            dc_next   = '0;
            ha_next   = '0;
            rs_next   = '0;
            tc_next   = '0;
            open_next = 1'b0;
        end
    end

    assign rec_cnt = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg   <= '0;
            ha_reg   <= '0;
            rs_reg   <= '0;
            tc_reg   <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            dc_reg   <= dc_next;
            ha_reg   <= ha_next;
            rs_reg   <= rs_next;
            tc_reg   <= tc_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gb_reg <= gb_next;
    end

endmodule
`default_nettype wire

FILE: src/ide_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module ide_out_buf
    import ide_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire rec_t       recs [3],
    input  wire logic [1:0] rec_cnt,
    output logic            can_take,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rec_t            out_rec
);

    rec_t       slot_reg [3];
    logic [1:0] head_reg;
    logic [1:0] rem_reg;
    logic       pop;

    assign out_valid = rem_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign can_take  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop);
    assign out_rec   = slot_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            rem_reg  <= '0;
        end
        else if (load)
        begin
            head_reg <= '0;
            rem_reg  <= rec_cnt;
        end
        else if (pop)
        begin
            head_reg <= head_reg + 2'd1;
            rem_reg  <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= recs;
        end
    end

endmodule
`default_nettype wire

FILE: src/interval_diff_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an input is registered in the issue stage; its results load into the output buffer when that stage fires.
// Throughput: one input per cycle while out_ready is high; an input with k results
// holds the input side until the output buffer pops the last of its records.
// Base store: row memory, one row read per compare, one row or lane write per cycle.
// Reset: asynchronous, active low; control registers at their reset values, base store and data registers unknown.
module interval_diff_encoder
    import ide_pkg::*;
#(
    parameter int BASE_WORDS = 4096
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire logic [11:0]       word_index,
    input  wire logic [WORD_W-1:0] word_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        record_kind,
    output logic      [POS_W-1:0]  diff_address,
    output logic      [WORD_W-1:0] diff_value,
    output logic                   last,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [POS_W-1:0]  cfg_data
);

    localparam int ROWS = BASE_WORDS / LANES;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [POS_W-1:0] window_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] end_reg;
    logic [POS_W-1:0] cfg_aligned;
    logic [POS_W-1:0] start_value;
    logic             restart;
    logic             fire;
    logic             can_take;
    logic             s1_valid;
    item_t            s1_item;
    logic [RAW-1:0]   s1_row;
    logic             rd_en;
    logic [RAW-1:0]   rd_row;
    logic [ROW_W-1:0] base_row;
    wr_t              wr;
    rec_t             recs [3];
    logic [1:0]       rec_cnt;
    rec_t             out_rec;

    assign cfg_aligned = {cfg_data[POS_W-1:3], 3'b000};
    assign restart     = cfg_we && ((cfg_index == REG_START) || (cfg_index == REG_END));
    assign start_value = (cfg_we && (cfg_index == REG_START)) ? cfg_aligned : start_reg;
    assign fire        = s1_valid && can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= POS_W'(64);
            start_reg  <= '0;
            end_reg    <= POS_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data;
                REG_START:  start_reg  <= cfg_aligned;
                REG_END:    end_reg    <= cfg_aligned;
                default:    ;
            endcase
        end
    end

    ide_issue #(.ROWS(ROWS), .RAW(RAW)) u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .command     (command),
        .word_index  (word_index),
        .word_value  (word_value),
        .in_ready    (in_ready),
        .fire        (fire),
        .restart     (restart),
        .start_value (start_value),
        .end_value   (end_reg),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .s1_row      (s1_row),
        .rd_en       (rd_en),
        .rd_row      (rd_row)
    );

    ide_base_mem #(.ROWS(ROWS), .RAW(RAW)) u_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_row   (rd_row),
        .wr       (wr),
        .wr_row   (s1_row),
        .base_row (base_row)
    );

    ide_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .restart  (restart),
        .item     (s1_item),
        .base_row (base_row),
        .window   (window_reg),
        .wr       (wr),
        .recs     (recs),
        .rec_cnt  (rec_cnt)
    );

    ide_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .recs      (recs),
        .rec_cnt   (rec_cnt),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (out_rec)
    );

    assign record_kind  = out_rec.kind;
    assign diff_address = out_rec.addr;
    assign diff_value   = out_rec.value;
    assign last         = out_rec.last;

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid)
        else $error("accepted transfer did not reach the compare stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !fire) |-> !in_ready)
        else $error("input taken while the compare stage is stalled");

    a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_item.cmd == CMD_COMPARE) && s1_item.empty)
        |=> (out_valid && (record_kind == KIND_DONE) && last))
        else $error("empty pass did not present a done record");

    a_lane_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && (wr.lanes != '1)) |-> $onehot(wr.lanes))
        else $error("partial base write touches more than one lane");

endmodule
`default_nettype wire
